// ===== rtl/core/ids_cde_pkg.sv =====
// Package for the bounded-drift insertion/deletion/substitution channel.
// Holds register indexes, field widths and default parameter values.
// No dependencies.
`default_nettype none

package ids_cde_pkg;

    // default draw / probability resolution in bits
    localparam int PROB_BITS_DEF = 16;

    // field widths
    localparam int SYM_W   = 2;
    localparam int DRAW_W  = 16;
    localparam int PROB_W  = 15;
    localparam int DRIFT_W = 8;
    localparam int DMAX_W  = 7;
    localparam int CNT_W   = 2;
    localparam int CFG_A_W = 3;

    // packed stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_INS_PROB  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_DEL_PROB  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_SUB_PROB  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_DRIFT_MIN = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_DRIFT_MAX = 3'd4;

    // copy counts
    localparam logic [CNT_W-1:0] CNT_DELETE   = 2'd0;
    localparam logic [CNT_W-1:0] CNT_TRANSMIT = 2'd1;
    localparam logic [CNT_W-1:0] CNT_INSERT   = 2'd2;

    // reset values of the drift bounds
    localparam logic signed [DRIFT_W-1:0] DRIFT_MIN_RST = -8'sd8;
    localparam logic [DMAX_W-1:0]         DRIFT_MAX_RST = 7'd8;

endpackage

`default_nettype wire

// ===== rtl/core/ids_channel_drift_emulator.sv =====
// An input beat passes the input register and then the result register to become a result beat.
// Throughput: one symbol per cycle while the result stream is not stalled; the drift register feeds the next decision.
// Each register holds one beat, so input is taken while a result waits only if the input register is empty.
// Reset (synchronous, active low): drift 0, probabilities 0, bounds -8 / +8,
// both pipeline stages empty. No clearing pass.
`default_nettype none

module ids_channel_drift_emulator #(
    parameter int PROB_BITS = ids_cde_pkg::PROB_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration write port
    input  wire                                i_cfg_we,
    input  wire  [ids_cde_pkg::CFG_A_W-1:0]    i_cfg_addr,
    input  wire  [ids_cde_pkg::PROB_W-1:0]     i_cfg_data,
    // input stream
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // symbol, drift_draw, sub_draw_a, sub_draw_b, sub_offset_a, sub_offset_b, zero pad
    input  wire  [ids_cde_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // first
    input  wire                                i_s_tuser,
    // result stream
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // copy_count, out_symbol_a, out_symbol_b, drift_after, zero pad
    output logic [ids_cde_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import ids_cde_pkg::*;

    // draws are reduced to PROB_BITS bits
    localparam logic [DRAW_W-1:0] DRAW_MASK =
        DRAW_W'((33'(1) << PROB_BITS) - 33'(1));

    // configuration registers
    logic [PROB_W-1:0]         r_ins_prob;
    logic [PROB_W-1:0]         r_del_prob;
    logic [PROB_W-1:0]         r_sub_prob;
    logic signed [DRIFT_W-1:0] r_drift_min;
    logic [DMAX_W-1:0]         r_drift_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_prob  <= '0;
            r_del_prob  <= '0;
            r_sub_prob  <= '0;
            r_drift_min <= DRIFT_MIN_RST;
            r_drift_max <= DRIFT_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_INS_PROB:  r_ins_prob  <= i_cfg_data;
                REG_DEL_PROB:  r_del_prob  <= i_cfg_data;
                REG_SUB_PROB:  r_sub_prob  <= i_cfg_data;
                REG_DRIFT_MIN: r_drift_min <= i_cfg_data[DRIFT_W-1:0];
                REG_DRIFT_MAX: r_drift_max <= i_cfg_data[DMAX_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    logic r_in_valid;
    logic r_out_valid;
    logic w_out_load;
    logic w_adv;

    assign w_out_load = !r_out_valid || i_m_tready;
    assign w_adv      = r_in_valid && w_out_load;
    assign o_s_tready = !r_in_valid || w_out_load;
    assign o_m_tvalid = r_out_valid;

    // input register
    logic [SYM_W-1:0]  r_sym;
    logic              r_first;
    logic [DRAW_W-1:0] r_drift_draw;
    logic [DRAW_W-1:0] r_sub_draw_a;
    logic [DRAW_W-1:0] r_sub_draw_b;
    logic [SYM_W-1:0]  r_off_a;
    logic [SYM_W-1:0]  r_off_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_sym        <= i_s_tdata[1:0];
            r_drift_draw <= i_s_tdata[17:2];
            r_sub_draw_a <= i_s_tdata[33:18];
            r_sub_draw_b <= i_s_tdata[49:34];
            r_off_a      <= i_s_tdata[51:50];
            r_off_b      <= i_s_tdata[53:52];
            r_first      <= i_s_tuser;
        end
    end

    // drift decision
    logic signed [DRIFT_W-1:0] r_drift;
    logic signed [DRIFT_W-1:0] w_cur;
    logic signed [DRIFT_W-1:0] w_dmax;
    logic [DRAW_W-1:0]         w_d;
    logic [DRAW_W:0]           w_ins_del;
    logic                      w_hit_ins;
    logic                      w_hit_del;
    logic [CNT_W-1:0]          w_cnt;
    logic [CNT_W-1:0]          n_cnt;
    logic signed [DRIFT_W-1:0] n_drift;

    assign w_cur     = r_first ? '0 : r_drift;
    assign w_dmax    = $signed({1'b0, r_drift_max});
    assign w_d       = r_drift_draw & DRAW_MASK;
    assign w_ins_del = (DRAW_W+1)'(r_ins_prob) + (DRAW_W+1)'(r_del_prob);
    assign w_hit_ins = w_d < DRAW_W'(r_ins_prob);

    always_comb begin
        w_hit_del = 1'b0;
        priority if (w_cur == r_drift_min) begin
            w_cnt = w_hit_ins ? CNT_INSERT : CNT_TRANSMIT;
        end else if (w_cur == w_dmax) begin
            w_hit_del = w_d < DRAW_W'(r_del_prob);
            w_cnt     = w_hit_del ? CNT_DELETE : CNT_TRANSMIT;
        end else begin
            w_hit_del = {1'b0, w_d} < w_ins_del;
            w_cnt     = w_hit_ins ? CNT_INSERT :
                        (w_hit_del ? CNT_DELETE : CNT_TRANSMIT);
        end
    end

    // keep the drift inside its 8-bit range
    always_comb begin
        n_cnt   = w_cnt;
        n_drift = w_cur;
        unique case (w_cnt)
            CNT_INSERT: begin
                if (w_cur == 8'sd127) n_cnt = CNT_TRANSMIT;
                else                  n_drift = w_cur + 8'sd1;
            end
            CNT_DELETE: begin
                if (w_cur == -8'sd128) n_cnt = CNT_TRANSMIT;
                else                   n_drift = w_cur - 8'sd1;
            end
            default: ;
        endcase
    end

    // substitution of each copy
    logic [SYM_W-1:0] w_sub_a;
    logic [SYM_W-1:0] w_sub_b;
    logic [SYM_W-1:0] n_sym_a;
    logic [SYM_W-1:0] n_sym_b;

    assign w_sub_a = ((r_sub_draw_a & DRAW_MASK) < DRAW_W'(r_sub_prob)) ?
                     r_sym + 2'd1 + r_off_a : r_sym;
    assign w_sub_b = ((r_sub_draw_b & DRAW_MASK) < DRAW_W'(r_sub_prob)) ?
                     r_sym + 2'd1 + r_off_b : r_sym;
    assign n_sym_a = (n_cnt != CNT_DELETE) ? w_sub_a : '0;
    assign n_sym_b = (n_cnt == CNT_INSERT) ? w_sub_b : '0;

    // drift state and result register
    logic [CNT_W-1:0]   r_cnt;
    logic [SYM_W-1:0]   r_sym_a;
    logic [SYM_W-1:0]   r_sym_b;
    logic [DRIFT_W-1:0] r_drift_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_drift     <= '0;
        end else begin
            if (w_out_load) r_out_valid <= r_in_valid;
            if (w_adv)      r_drift     <= n_drift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cnt       <= n_cnt;
            r_sym_a     <= n_sym_a;
            r_sym_b     <= n_sym_b;
            r_drift_out <= n_drift;
        end
    end

    assign o_m_tdata = {2'b00, r_drift_out, r_sym_b, r_sym_a, r_cnt};

`ifndef SYNTH
    // a result beat always carries the drift that the state now holds
    a_drift_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_drift_out == r_drift))
        else $error("result drift differs from drift state");

    // unused copies read as zero
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_cnt == CNT_INSERT) || (r_sym_b == '0)) &&
                        ((r_cnt != CNT_DELETE) || (r_sym_a == '0)))
        else $error("unused copy not zero");

    // drift moves by at most one within a sequence
    a_drift_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_first) |=>
            ((r_drift == $past(r_drift)) ||
             (r_drift == $past(r_drift) + 8'sd1) ||
             (r_drift == $past(r_drift) - 8'sd1)))
        else $error("drift jumped by more than one");

    // copy count is never the unused code
    a_cnt_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_cnt != 2'd3))
        else $error("copy count out of range");
`endif

endmodule

`default_nettype wire
